// ===== rtl/core/assert_macros.svh =====
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define WTO_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define WTO_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define WTO_ASSERT(label, clk, rst, prop, msg)

`define WTO_NEVER(label, clk, rst, expr, msg)

`endif

`endif

// ===== rtl/core/wto_pkg.sv =====
`default_nettype none

package wto_pkg;

   typedef enum logic [1:0] {
      FUNC_TICK        = 2'd0,
      FUNC_PITCH_EDGE  = 2'd1,
      FUNC_VOLUME_EDGE = 2'd2,
      FUNC_TABLE_WRITE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CSR_WAVE_SELECT = 2'd0,
      CSR_PHASE_STEP  = 2'd1,
      CSR_VOLUME      = 2'd2
   } csr_index_type;

   localparam int PHASE_BITS   = 16;
   localparam int SAMPLE_BITS  = 16;
   localparam int VOLUME_BITS  = 8;
   localparam int SELECT_BITS  = 3;
   localparam int TADDR_BITS   = 10;
   localparam int TIMER_BITS   = 16;
   localparam int COUNT_BITS   = 8;
   localparam int DAC_BITS     = 12;
   localparam int PRODUCT_BITS = SAMPLE_BITS + VOLUME_BITS;
   localparam int SCALE_SHIFT  = 9;
   localparam int DAC_CENTRE   = 1748;
   localparam int DAC_MAX      = 4095;
   localparam int LATCH_COUNT  = 3;
   localparam int READY_COUNT  = 5;

   typedef struct packed {
      logic [TIMER_BITS-1:0] pitch_period;
      logic                  pitch_ready;
      logic [TIMER_BITS-1:0] volume_period;
      logic                  volume_ready;
   } meter_type;

endpackage

`default_nettype wire

// ===== rtl/core/wavetable_oscillator_with_period_capture.sv =====
`default_nettype none

// Wavetable oscillator with pitch and volume period meters. Requests carry a kind in
// req_tuser: sample tick, pitch edge, volume edge or table write. Only a sample tick
// gives a response. The block takes one request per clock unless the response side
// stalls; a tick's response passes through the three-stage path of wave memory read,
// volume multiply, and centre offset with clamp. The wave memory is not cleared:
// load every entry that will be played before sending ticks. The user must make
// csr_ port configuration writes only while no response is pending; not enforced.
module wavetable_oscillator_with_period_capture
   import wto_pkg::*;
#(
   parameter int TABLE_ADDR_BITS = 10,
   parameter int TABLE_COUNT     = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // func
   input  wire logic [1:0]  req_tuser,
   // pitch_pin, volume_pin, timer_value, table_select, table_address, table_data
   input  wire logic [47:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // dac_code, pitch_period, pitch_ready, volume_period, volume_ready
   output logic [47:0]      rsp_tdata,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int SEL_BITS   = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
   localparam int MEM_ABITS  = SEL_BITS + TABLE_ADDR_BITS;
   localparam int MEM_DEPTH  = TABLE_COUNT << TABLE_ADDR_BITS;
   localparam int MAG_BITS   = PRODUCT_BITS - SCALE_SHIFT;

   // request fields
   func_type                func;
   logic                    pitch_pin;
   logic                    volume_pin;
   logic [TIMER_BITS-1:0]   timer_value;
   logic [SELECT_BITS-1:0]  table_select;
   logic [TADDR_BITS-1:0]   table_address;
   logic [SAMPLE_BITS-1:0]  table_data;

   assign func          = func_type'(req_tuser);
   assign pitch_pin     = req_tdata[0];
   assign volume_pin    = req_tdata[1];
   assign timer_value   = req_tdata[17:2];
   assign table_select  = req_tdata[20:18];
   assign table_address = req_tdata[30:21];
   assign table_data    = req_tdata[46:31];

   // configuration
   logic [SELECT_BITS-1:0] wave_select_ff;
   logic [PHASE_BITS-1:0]  phase_step_ff;
   logic [VOLUME_BITS-1:0] volume_ff;

   // oscillator and meter state
   logic [PHASE_BITS-1:0]  phase_ff;
   logic [COUNT_BITS-1:0]  pitch_count_ff, pitch_count_in;
   logic [COUNT_BITS-1:0]  volume_count_ff, volume_count_in;
   logic [TIMER_BITS-1:0]  pitch_last_ff;
   logic [TIMER_BITS-1:0]  pitch_period_ff, pitch_period_in;
   logic [TIMER_BITS-1:0]  volume_edge_ff;
   logic [TIMER_BITS-1:0]  volume_last_ff;
   logic [TIMER_BITS-1:0]  volume_period_ff, volume_period_in;
   logic                   pitch_latch, volume_latch;

   // pipeline
   logic                    s1_valid_ff, s2_valid_ff, out_valid_ff;
   meter_type               s1_meter_ff, s2_meter_ff, meter_in;
   logic [PRODUCT_BITS-1:0] s2_product_ff, product_in;
   logic                    s2_negative_ff;
   logic [DAC_BITS-1:0]     out_dac_ff, dac_in;
   meter_type               out_meter_ff;
   logic                    en0, en1, en2;
   logic                    accept, accept_tick, table_write;

   // wave memory ports
   logic [SEL_BITS-1:0]        rd_sel, wr_sel;
   logic [MEM_ABITS-1:0]       rd_addr, wr_addr;
   logic [TABLE_ADDR_BITS+9:0] taddr_wide;
   logic [SAMPLE_BITS-1:0]     rd_data;
   logic [SAMPLE_BITS-1:0]     magnitude;
   logic [MAG_BITS-1:0]        scaled;
   logic [DAC_BITS+4:0]        sum_up;

   assign en2 = !out_valid_ff || rsp_tready;
   assign en1 = !s2_valid_ff || en2;
   assign en0 = !s1_valid_ff || en1;

   assign req_tready  = en0;
   assign accept      = req_tvalid && en0;
   assign accept_tick = accept && (func == FUNC_TICK);
   assign table_write = accept && (func == FUNC_TABLE_WRITE) &&
                        ({1'b0, table_select} < 4'(TABLE_COUNT));

   // a select beyond the table count plays table 0
   always_comb begin
      if ({1'b0, wave_select_ff} < 4'(TABLE_COUNT)) begin
         rd_sel = wave_select_ff[SEL_BITS-1:0];
      end else begin
         rd_sel = '0;
      end
   end

   assign wr_sel     = table_select[SEL_BITS-1:0];
   assign taddr_wide = (TABLE_ADDR_BITS + 10)'(table_address);
   assign rd_addr    = {rd_sel, phase_ff[PHASE_BITS-1 -: TABLE_ADDR_BITS]};
   assign wr_addr    = {wr_sel, taddr_wide[TABLE_ADDR_BITS-1:0]};

   wto_ram #(
      .WIDTH     (SAMPLE_BITS),
      .DEPTH     (MEM_DEPTH),
      .ADDR_BITS (MEM_ABITS)
   ) u_wave_ram (
      .clock   (clock),
      .wr_en   (table_write),
      .wr_addr (wr_addr),
      .wr_data (table_data),
      .rd_en   (accept_tick),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // meters as seen after this tick
   always_comb begin
      pitch_count_in  = pitch_pin ? pitch_count_ff + 1'b1 : pitch_count_ff;
      volume_count_in = volume_pin ? volume_count_ff + 1'b1 : volume_count_ff;
      pitch_latch     = (pitch_count_in == COUNT_BITS'(LATCH_COUNT));
      volume_latch    = (volume_count_in == COUNT_BITS'(LATCH_COUNT));
      pitch_period_in  = pitch_latch ? timer_value - pitch_last_ff : pitch_period_ff;
      volume_period_in = volume_latch ? volume_edge_ff - volume_last_ff : volume_period_ff;
      meter_in.pitch_period  = pitch_period_in;
      meter_in.pitch_ready   = (pitch_count_in == COUNT_BITS'(READY_COUNT));
      meter_in.volume_period = volume_period_in;
      meter_in.volume_ready  = (volume_count_in == COUNT_BITS'(READY_COUNT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_select_ff   <= '0;
         phase_step_ff    <= '0;
         volume_ff        <= '0;
         phase_ff         <= '0;
         pitch_count_ff   <= '0;
         volume_count_ff  <= '0;
         pitch_last_ff    <= '0;
         pitch_period_ff  <= '0;
         volume_edge_ff   <= '0;
         volume_last_ff   <= '0;
         volume_period_ff <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_WAVE_SELECT: wave_select_ff <= csr_data[SELECT_BITS-1:0];
               CSR_PHASE_STEP:  phase_step_ff  <= csr_data;
               CSR_VOLUME:      volume_ff      <= csr_data[VOLUME_BITS-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            case (func)
               FUNC_TICK: begin
                  phase_ff         <= phase_ff + phase_step_ff;
                  pitch_count_ff   <= pitch_count_in;
                  volume_count_ff  <= volume_count_in;
                  pitch_period_ff  <= pitch_period_in;
                  volume_period_ff <= volume_period_in;
                  if (pitch_latch) begin
                     pitch_last_ff <= timer_value;
                  end
                  if (volume_latch) begin
                     volume_last_ff <= volume_edge_ff;
                  end
               end
               FUNC_PITCH_EDGE: begin
                  pitch_count_ff <= '0;
               end
               FUNC_VOLUME_EDGE: begin
                  volume_edge_ff  <= timer_value;
                  volume_count_ff <= '0;
               end
               default: ;
            endcase
         end
      end
   end

   // magnitude times volume, negative samples take the subtract path
   assign magnitude  = rd_data[SAMPLE_BITS-1] ? SAMPLE_BITS'(-rd_data) : rd_data;
   assign product_in = PRODUCT_BITS'(magnitude) * PRODUCT_BITS'(volume_ff);

   // centre offset and clamp
   assign scaled = s2_product_ff[PRODUCT_BITS-1:SCALE_SHIFT];
   assign sum_up = (DAC_BITS + 5)'(DAC_CENTRE) + (DAC_BITS + 5)'(scaled);

   always_comb begin
      if (s2_negative_ff) begin
         if ((DAC_BITS + 5)'(scaled) > (DAC_BITS + 5)'(DAC_CENTRE)) begin
            dac_in = '0;
         end else begin
            dac_in = DAC_BITS'(DAC_CENTRE) - DAC_BITS'(scaled);
         end
      end else if (sum_up > (DAC_BITS + 5)'(DAC_MAX)) begin
         dac_in = DAC_BITS'(DAC_MAX);
      end else begin
         dac_in = sum_up[DAC_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (en0) begin
            s1_valid_ff <= accept_tick;
         end
         if (en1) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (en2) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
      if (accept_tick) begin
         s1_meter_ff <= meter_in;
      end
      if (en1) begin
         s2_meter_ff    <= s1_meter_ff;
         s2_product_ff  <= product_in;
         s2_negative_ff <= rd_data[SAMPLE_BITS-1];
      end
      if (en2) begin
         out_dac_ff   <= dac_in;
         out_meter_ff <= s2_meter_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00,
                        out_meter_ff.volume_ready,
                        out_meter_ff.volume_period,
                        out_meter_ff.pitch_ready,
                        out_meter_ff.pitch_period,
                        out_dac_ff};

`include "assert_macros.svh"

   `WTO_ASSERT(a_tick_enters_pipe, clock, reset, accept_tick |=> s1_valid_ff, "tick lost after read")
   `WTO_ASSERT(a_stall_only_when_full, clock, reset, !req_tready |-> (s1_valid_ff && s2_valid_ff && out_valid_ff), "request stalled with free stage")
   `WTO_ASSERT(a_read_data_held, clock, reset, (s1_valid_ff && !en1) |=> $stable(rd_data), "sample lost while stalled")

endmodule

`default_nettype wire

// ===== rtl/core/wto_ram.sv =====
`default_nettype none

module wto_ram #(
   parameter int WIDTH     = 16,
   parameter int DEPTH     = 8192,
   parameter int ADDR_BITS = 13
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== verif/wavetable_oscillator_with_period_capture_tb.sv =====
`default_nettype none

module wavetable_oscillator_with_period_capture_tb;
   import wto_pkg::*;

   localparam logic [1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [DAC_BITS-1:0] dac;
      meter_type           meter;
   } sample_type;

   class tone_scoreboard;
      logic [SAMPLE_BITS-1:0] wave_mem [0:8191];
      bit                     written [0:8191];
      logic [PHASE_BITS-1:0]  phase;
      logic [COUNT_BITS-1:0]  pitch_count;
      logic [COUNT_BITS-1:0]  volume_count;
      logic [TIMER_BITS-1:0]  pitch_last;
      logic [TIMER_BITS-1:0]  pitch_period;
      logic [TIMER_BITS-1:0]  volume_edge;
      logic [TIMER_BITS-1:0]  volume_last;
      logic [TIMER_BITS-1:0]  volume_period;
      logic [SELECT_BITS-1:0] wave_sel;
      logic [PHASE_BITS-1:0]  step;
      logic [VOLUME_BITS-1:0] vol;
      sample_type             samples_due[$];
      int                     mismatches;
      int                     checked;

      function new();
         phase = '0;
         pitch_count = '0;
         volume_count = '0;
         pitch_last = '0;
         pitch_period = '0;
         volume_edge = '0;
         volume_last = '0;
         volume_period = '0;
         wave_sel = '0;
         step = '0;
         vol = '0;
         mismatches = 0;
         checked = 0;
      endfunction

      function int pending();
         return samples_due.size();
      endfunction

      // entry that the next tick will play
      function logic [12:0] next_read_index();
         return {wave_sel, phase[15:6]};
      endfunction

      function bit next_read_written();
         return written[{wave_sel, phase[15:6]}];
      endfunction

      function void set_register(logic [1:0] idx, logic [15:0] data);
         case (idx)
            CSR_WAVE_SELECT: wave_sel = data[SELECT_BITS-1:0];
            CSR_PHASE_STEP:  step = data;
            CSR_VOLUME:      vol = data[VOLUME_BITS-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(func_type f, logic [47:0] d);
         logic                   pp;
         logic                   vp;
         logic [TIMER_BITS-1:0]  timer;
         logic [SELECT_BITS-1:0] ts;
         logic [TADDR_BITS-1:0]  ta;
         logic [SAMPLE_BITS-1:0] td;
         sample_type             e;
         int                     s;
         int                     code;
         pp = d[0];
         vp = d[1];
         timer = d[17:2];
         ts = d[20:18];
         ta = d[30:21];
         td = d[46:31];
         case (f)
            FUNC_PITCH_EDGE: pitch_count = '0;
            FUNC_VOLUME_EDGE: begin
               volume_edge = timer;
               volume_count = '0;
            end
            FUNC_TABLE_WRITE: begin
               wave_mem[{ts, ta}] = td;
               written[{ts, ta}] = 1'b1;
            end
            default: begin
               s = $signed(wave_mem[{wave_sel, phase[15:6]}]);
               if (s > 0) begin
                  code = DAC_CENTRE + ((s * int'(vol)) >> SCALE_SHIFT);
               end else begin
                  code = DAC_CENTRE - (((-s) * int'(vol)) >> SCALE_SHIFT);
               end
               if (code < 0) code = 0;
               if (code > DAC_MAX) code = DAC_MAX;
               e.dac = code[DAC_BITS-1:0];
               phase = phase + step;
               if (pp) pitch_count = pitch_count + 1'b1;
               if (pitch_count == LATCH_COUNT) begin
                  pitch_period = timer - pitch_last;
                  pitch_last = timer;
               end
               if (vp) volume_count = volume_count + 1'b1;
               if (volume_count == LATCH_COUNT) begin
                  volume_period = volume_edge - volume_last;
                  volume_last = volume_edge;
               end
               e.meter.pitch_period = pitch_period;
               e.meter.pitch_ready = (pitch_count == READY_COUNT);
               e.meter.volume_period = volume_period;
               e.meter.volume_ready = (volume_count == READY_COUNT);
               samples_due.push_back(e);
            end
         endcase
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_response(logic [47:0] d);
         sample_type e;
         if (samples_due.size() == 0) begin
            report($sformatf("response %h with none due", d));
            return;
         end
         e = samples_due.pop_front();
         checked++;
         if (d[11:0] !== e.dac)
            report($sformatf("dac_code %0d, due %0d", d[11:0], e.dac));
         if (d[27:12] !== e.meter.pitch_period)
            report($sformatf("pitch_period %h, due %h", d[27:12], e.meter.pitch_period));
         if (d[28] !== e.meter.pitch_ready)
            report($sformatf("pitch_ready %b, due %b", d[28], e.meter.pitch_ready));
         if (d[44:29] !== e.meter.volume_period)
            report($sformatf("volume_period %h, due %h", d[44:29], e.meter.volume_period));
         if (d[45] !== e.meter.volume_ready)
            report($sformatf("volume_ready %b, due %b", d[45], e.meter.volume_ready));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // func
   logic [1:0]  req_tuser;
   // pitch_pin, volume_pin, timer_value, table_select, table_address, table_data
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // dac_code, pitch_period, pitch_ready, volume_period, volume_ready
   logic [47:0] rsp_tdata;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   tone_scoreboard sb;
   bit             no_idle;
   int             hold_request;
   int             n_writes;
   int             n_edges;
   int             n_settings;

   wavetable_oscillator_with_period_capture dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [47:0] pack_request(logic pp, logic vp, logic [15:0] timer,
                                                logic [2:0] ts, logic [9:0] ta,
                                                logic [15:0] td);
      return {1'b0, td, ta, ts, timer, vp, pp};
   endfunction

   function automatic logic [15:0] pick_extreme(int hi);
      int r;
      r = $urandom_range(9);
      if (r < 3) return '0;
      if (r < 6) return 16'(hi);
      return 16'($urandom_range(hi, 0));
   endfunction

   task automatic send_request(func_type f, logic [47:0] d);
      while (!no_idle && $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= f;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(f, d);
      if (f == FUNC_TABLE_WRITE) n_writes++;
      if (f == FUNC_PITCH_EDGE || f == FUNC_VOLUME_EDGE) n_edges++;
      @(negedge clock);
   endtask

   // load the entry the next tick plays if it has never been written
   task automatic prepare_tick();
      logic [12:0] idx;
      if (!sb.next_read_written()) begin
         idx = sb.next_read_index();
         send_request(FUNC_TABLE_WRITE, pack_request(1'($urandom), 1'($urandom),
                      16'($urandom), idx[12:10], idx[9:0], 16'($urandom)));
      end
   endtask

   task automatic send_tick(logic pp, logic vp, logic [15:0] timer);
      prepare_tick();
      send_request(FUNC_TICK, pack_request(pp, vp, timer, 3'($urandom), 10'($urandom),
                                           16'($urandom)));
   endtask

   task automatic send_random(int tick_pct, int edge_pct, int pin_pct);
      int          r;
      logic [47:0] d;
      func_type    f;
      r = $urandom_range(99);
      d = pack_request($urandom_range(99) < pin_pct, $urandom_range(99) < pin_pct,
                       16'($urandom), 3'($urandom), 10'($urandom), 16'($urandom));
      if (r < edge_pct) f = FUNC_PITCH_EDGE;
      else if (r < 2 * edge_pct) f = FUNC_VOLUME_EDGE;
      else if (r < 2 * edge_pct + tick_pct) f = FUNC_TICK;
      else f = FUNC_TABLE_WRITE;
      if (f == FUNC_TICK) prepare_tick();
      send_request(f, d);
   endtask

   task automatic write_register(logic [1:0] idx, logic [15:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      sb.set_register(idx, data);
      n_settings++;
      @(negedge clock);
   endtask

   task automatic program_registers(logic [15:0] ws, logic [15:0] st, logic [15:0] vo);
      write_register(CSR_WAVE_SELECT, ws);
      write_register(CSR_PHASE_STEP, st);
      write_register(CSR_VOLUME, vo);
      if ($urandom_range(1)) write_register(CSR_SPARE, 16'($urandom));
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // wait for every due response, then for the pipeline to drain
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // response side: random back-pressure plus long hold-offs on demand
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(99) >= 38);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   initial begin : limit
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      int          p;
      int          i;
      int          items;
      int          tick_pct;
      int          edge_pct;
      int          pin_pct;
      logic [15:0] ws;
      logic [15:0] st;
      logic [15:0] vo;
      sb = new();
      no_idle = 1'b0;
      hold_request = 0;
      n_writes = 0;
      n_edges = 0;
      n_settings = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = FUNC_TICK;
      req_tdata = '0;
      csr_write = 1'b0;
      csr_index = CSR_WAVE_SELECT;
      csr_data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      program_registers(16'd0, 16'd0, 16'd255);

      // full-scale samples at maximum volume clamp high and low
      send_request(FUNC_TABLE_WRITE, pack_request(1'b0, 1'b0, 16'd0, 3'd0, 10'd0, 16'h7fff));
      send_tick(1'b1, 1'b1, 16'd100);
      send_request(FUNC_TABLE_WRITE, pack_request(1'b0, 1'b0, 16'd0, 3'd0, 10'd0, 16'h8000));
      send_tick(1'b1, 1'b1, 16'd250);
      // zero sample plays the centre code
      send_request(FUNC_TABLE_WRITE, pack_request(1'b0, 1'b0, 16'd0, 3'd0, 10'd0, 16'h0000));
      send_tick(1'b1, 1'b1, 16'hffff);
      send_request(FUNC_TABLE_WRITE, pack_request(1'b0, 1'b0, 16'd0, 3'd0, 10'd0, 16'h0001));
      send_tick(1'b1, 1'b0, 16'h0000);
      // edges clear the counts, then qualify to latch and ready
      send_request(FUNC_VOLUME_EDGE,
                   pack_request(1'b0, 1'b0, 16'h1234, 3'd0, 10'd0, 16'd0));
      send_request(FUNC_PITCH_EDGE,
                   pack_request(1'b0, 1'b0, 16'h0000, 3'd0, 10'd0, 16'd0));
      send_tick(1'b1, 1'b1, 16'h0010);
      send_tick(1'b1, 1'b1, 16'h0020);
      send_tick(1'b1, 1'b1, 16'h0030);
      send_tick(1'b1, 1'b1, 16'h0040);
      send_tick(1'b1, 1'b1, 16'h0050);
      send_tick(1'b0, 1'b0, 16'h0060);
      send_tick(1'b1, 1'b1, 16'h0070);
      // a low pin at count three latches again
      send_request(FUNC_PITCH_EDGE,
                   pack_request(1'b0, 1'b0, 16'h0000, 3'd0, 10'd0, 16'd0));
      send_request(FUNC_VOLUME_EDGE,
                   pack_request(1'b0, 1'b0, 16'hfedc, 3'd0, 10'd0, 16'd0));
      send_tick(1'b1, 1'b1, 16'h0100);
      send_tick(1'b1, 1'b1, 16'h0200);
      send_tick(1'b1, 1'b1, 16'h0300);
      send_tick(1'b0, 1'b0, 16'h0400);

      for (p = 0; p < 16; p++) begin
         settle();
         ws = {13'($urandom), 3'(pick_extreme(7))};
         st = pick_extreme(65535);
         vo = {8'($urandom), 8'(pick_extreme(255))};
         if (p == 0) begin
            ws = 16'd7;
            st = 16'hffff;
            vo = 16'd0;
         end
         program_registers(ws, st, vo);
         items = 55;
         tick_pct = $urandom_range(80, 60);
         edge_pct = $urandom_range(8, 2);
         pin_pct = $urandom_range(95, 50);
         no_idle = (p == 8);
         if (p == 2) begin
            // long hold-off on the response side while requests keep coming
            hold_request = 400;
            items = 150;
            tick_pct = 90;
         end
         if (p == 5) begin
            // long high runs so the qualify counters wrap
            items = 320;
            tick_pct = 95;
            edge_pct = 0;
            pin_pct = 100;
         end
         for (i = 0; i < items; i++) send_random(tick_pct, edge_pct, pin_pct);
      end
      no_idle = 1'b0;

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("run covered %0d checked samples, %0d table writes, %0d edge requests",
               sb.checked, n_writes, n_edges);
      $display("and %0d register writes across 17 settings, with %0d mismatches",
               n_settings, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/wto_pkg.sv
rtl/core/wto_ram.sv
rtl/core/wavetable_oscillator_with_period_capture.sv
verif/wavetable_oscillator_with_period_capture_tb.sv
